### sv/pfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types and constants of the Playfair stream cipher.
// ----------------------------------------------------------------------------
package pfc_pkg;

   // A letter index, 0 is A.
   typedef logic [4:0] letter_type;

   // The 5x5 key square, row major, cell 0 at the top left.
   typedef letter_type [24:0] square_type;

   localparam letter_type LETTER_I = 5'd8;
   localparam letter_type LETTER_J = 5'd9;
   localparam letter_type LETTER_X = 5'd23;
   localparam letter_type LETTER_Z = 5'd25;

   localparam logic [7:0] ASCII_UPPER_A = 8'd65;
   localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
   localparam logic [7:0] ASCII_LOWER_A = 8'd97;
   localparam logic [7:0] ASCII_LOWER_Z = 8'd122;

   typedef enum logic [1:0] {
      CSR_CIPHER_MODE = 2'd0,
      CSR_SQUARE_LOW  = 2'd1,
      CSR_SQUARE_MID  = 2'd2,
      CSR_SQUARE_END  = 2'd3
   } csr_index_type;

   // One unit of work for the back end: at most one digraph to transform.
   typedef struct packed {
      logic       dec;     // decrypt rules and filler removal
      logic       xform;   // first/second form a digraph to transform
      logic       twice;   // encrypt: the digraph is sent a second time
      logic       fin;     // the byte closed the message
      letter_type first;
      letter_type second;
   } digraph_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### sv/pfc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_queue
// Small register queue of digraph work between the front and back ends.
// ----------------------------------------------------------------------------
module pfc_queue #(
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  pfc_pkg::digraph_type     push_entry,
   input  logic                     pop,
   output logic                     pop_valid,
   output pfc_pkg::digraph_type     pop_entry,
   output pfc_pkg::queue_status_type status
);
   import pfc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   digraph_type             entries_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_valid    = !status.empty;
   assign pop_entry    = entries_ff[rd_ptr_ff];

   assign do_push = push_valid && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### sv/pfc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_front
// Accepts text bytes, keeps letters only and pairs them into digraphs.
// ----------------------------------------------------------------------------
module pfc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cipher_mode,
   input  logic                      req_valid,
   input  logic [7:0]                req_char_in,
   input  logic                      req_final_byte,
   output logic                      req_stall,
   input  pfc_pkg::queue_status_type queue_status,
   output logic                      push_valid,
   output pfc_pkg::digraph_type      push_entry
);
   import pfc_pkg::*;

   letter_type  pending_letter_ff, pending_letter_in;
   logic        pending_valid_ff, pending_valid_in;
   logic        accept;
   logic        is_upper, is_lower, is_letter;
   logic [7:0]  offset;
   letter_type  raw_letter, letter;
   digraph_type entry;

   assign req_stall = queue_status.full;
   assign accept    = req_valid && !queue_status.full;

   assign is_upper   = (req_char_in >= ASCII_UPPER_A) && (req_char_in <= ASCII_UPPER_Z);
   assign is_lower   = (req_char_in >= ASCII_LOWER_A) && (req_char_in <= ASCII_LOWER_Z);
   assign is_letter  = is_upper || is_lower;
   assign offset     = req_char_in - (is_upper ? ASCII_UPPER_A : ASCII_LOWER_A);
   assign raw_letter = offset[4:0];
   assign letter     = (raw_letter == LETTER_J) ? LETTER_I : raw_letter;

   always_comb begin
      pending_letter_in = pending_letter_ff;
      pending_valid_in  = pending_valid_ff;
      entry             = '0;
      entry.dec         = cipher_mode;
      entry.fin         = req_final_byte;
      if (is_letter) begin
         if (!pending_valid_ff) begin
            pending_letter_in = letter;
            pending_valid_in  = 1'b1;
         end else if (!cipher_mode) begin
            entry.xform = 1'b1;
            entry.first = pending_letter_ff;
            // A doubled letter gets an X and stays open for the next pair.
            if (pending_letter_ff == letter) begin
               entry.second = LETTER_X;
            end else begin
               entry.second     = letter;
               pending_valid_in = 1'b0;
            end
         end else begin
            entry.xform      = 1'b1;
            entry.first      = pending_letter_ff;
            entry.second     = letter;
            pending_valid_in = 1'b0;
         end
      end
      if (req_final_byte) begin
         // A lone trailing letter is padded with X when encrypting.
         if (!cipher_mode && pending_valid_in) begin
            if (entry.xform) begin
               entry.twice = 1'b1;
            end else begin
               entry.xform  = 1'b1;
               entry.first  = pending_letter_in;
               entry.second = LETTER_X;
            end
         end
         pending_letter_in = '0;
         pending_valid_in  = 1'b0;
      end
   end

   assign push_valid = accept && (entry.xform || entry.fin);
   assign push_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_letter_ff <= '0;
         pending_valid_ff  <= 1'b0;
      end else if (accept) begin
         pending_letter_ff <= pending_letter_in;
         pending_valid_ff  <= pending_valid_in;
      end
   end

endmodule

### sv/pfc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_back
// Locates and transforms digraphs, removes decrypt fillers, sends letters.
// ----------------------------------------------------------------------------
module pfc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  pfc_pkg::square_type   square,
   input  logic                  pop_valid,
   input  pfc_pkg::digraph_type  pop_entry,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [6:0]            rsp_letter_out,
   output logic                  rsp_letter_valid,
   output logic                  rsp_end_of_message
);
   import pfc_pkg::*;

   function automatic letter_type locate(square_type sq, letter_type l);
      letter_type k;
      k = '0;
      for (int i = 24; i >= 0; i--) begin
         if (sq[i] == l) begin
            k = 5'(i);
         end
      end
      return k;
   endfunction

   function automatic logic [2:0] row_of(letter_type idx);
      logic [2:0] r;
      if (idx >= 5'd20) begin
         r = 3'd4;
      end else if (idx >= 5'd15) begin
         r = 3'd3;
      end else if (idx >= 5'd10) begin
         r = 3'd2;
      end else if (idx >= 5'd5) begin
         r = 3'd1;
      end else begin
         r = 3'd0;
      end
      return r;
   endfunction

   function automatic logic [2:0] col_of(letter_type idx, logic [2:0] r);
      letter_type c;
      c = idx - {r, 2'b00} - {2'b00, r};
      return c[2:0];
   endfunction

   function automatic logic [2:0] shift(logic [2:0] v, logic dec);
      logic [2:0] s;
      if (dec) begin
         s = (v == 3'd0) ? 3'd4 : v - 3'd1;
      end else begin
         s = (v == 3'd4) ? 3'd0 : v + 3'd1;
      end
      return s;
   endfunction

   function automatic letter_type cell_index(logic [2:0] r, logic [2:0] c);
      return {r, 2'b00} + {2'b00, r} + {2'b00, c};
   endfunction

   // Locate stage.
   logic        s1_valid_ff;
   digraph_type s1_entry_ff;
   letter_type  s1_p_ff, s1_q_ff;
   logic        s1_move;

   // Decrypt state.
   letter_type  held_plain_ff, held_plain_in;
   logic        held_valid_ff, held_valid_in;
   letter_type  previous_plain_ff, previous_plain_in;
   logic        previous_valid_ff, previous_valid_in;

   // Output burst.
   logic                burst_valid_ff, burst_valid_in;
   letter_type [3:0]    burst_words_ff, burst_words_in;
   logic [2:0]          burst_count_ff, burst_count_in;
   logic [1:0]          burst_idx_ff, burst_idx_in;
   logic                burst_fin_ff, burst_fin_in;
   logic                burst_bare_ff, burst_bare_in;
   logic                take, last_word, burst_free;

   logic [2:0]  r1, c1, r2, c2;
   letter_type  x_letter, y_letter;
   letter_type  src;
   letter_type [3:0] words;
   logic [2:0]  n_words;

   assign take       = burst_valid_ff && !rsp_stall;
   assign last_word  = ({1'b0, burst_idx_ff} + 3'd1) == burst_count_ff;
   assign burst_free = !burst_valid_ff || (take && last_word);
   assign s1_move    = s1_valid_ff && burst_free;
   assign pop        = pop_valid && (!s1_valid_ff || s1_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pop) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_entry_ff <= pop_entry;
         s1_p_ff     <= locate(square, pop_entry.first);
         s1_q_ff     <= locate(square, pop_entry.second);
      end
   end

   // Playfair rules on the located cells.
   always_comb begin
      r1 = row_of(s1_p_ff);
      c1 = col_of(s1_p_ff, r1);
      r2 = row_of(s1_q_ff);
      c2 = col_of(s1_q_ff, r2);
      if (r1 == r2) begin
         x_letter = square[cell_index(r1, shift(c1, s1_entry_ff.dec))];
         y_letter = square[cell_index(r2, shift(c2, s1_entry_ff.dec))];
      end else if (c1 == c2) begin
         x_letter = square[cell_index(shift(r1, s1_entry_ff.dec), c1)];
         y_letter = square[cell_index(shift(r2, s1_entry_ff.dec), c2)];
      end else begin
         x_letter = square[cell_index(r1, c2)];
         y_letter = square[cell_index(r2, c1)];
      end
   end

   // Build the list of letters this work item releases.
   always_comb begin
      held_plain_in     = held_plain_ff;
      held_valid_in     = held_valid_ff;
      previous_plain_in = previous_plain_ff;
      previous_valid_in = previous_valid_ff;
      words             = '0;
      n_words           = '0;
      src               = '0;
      if (!s1_entry_ff.dec) begin
         if (s1_entry_ff.xform) begin
            words[0] = x_letter;
            words[1] = y_letter;
            n_words  = 3'd2;
            if (s1_entry_ff.twice) begin
               words[2] = x_letter;
               words[3] = y_letter;
               n_words  = 3'd4;
            end
         end
      end else begin
         if (s1_entry_ff.xform) begin
            for (int j = 0; j < 2; j++) begin
               src = (j == 0) ? x_letter : y_letter;
               if (held_valid_in) begin
                  // An X between two equal letters is a filler.
                  if (!(held_plain_in == LETTER_X && previous_valid_in &&
                        previous_plain_in == src)) begin
                     words[n_words[1:0]] = held_plain_in;
                     n_words             = n_words + 3'd1;
                  end
                  previous_plain_in = held_plain_in;
                  previous_valid_in = 1'b1;
               end
               held_plain_in = src;
               held_valid_in = 1'b1;
            end
         end
         if (s1_entry_ff.fin && held_valid_in && held_plain_in != LETTER_X) begin
            words[n_words[1:0]] = held_plain_in;
            n_words             = n_words + 3'd1;
         end
      end
      if (s1_entry_ff.fin) begin
         held_plain_in     = '0;
         held_valid_in     = 1'b0;
         previous_plain_in = '0;
         previous_valid_in = 1'b0;
      end
   end

   always_comb begin
      burst_valid_in = burst_valid_ff;
      burst_words_in = burst_words_ff;
      burst_count_in = burst_count_ff;
      burst_idx_in   = burst_idx_ff;
      burst_fin_in   = burst_fin_ff;
      burst_bare_in  = burst_bare_ff;
      if (take) begin
         if (last_word) begin
            burst_valid_in = 1'b0;
         end else begin
            burst_idx_in = burst_idx_ff + 2'd1;
         end
      end
      if (s1_move && (n_words != '0 || s1_entry_ff.fin)) begin
         burst_valid_in = 1'b1;
         burst_words_in = words;
         burst_count_in = (n_words == '0) ? 3'd1 : n_words;
         burst_idx_in   = '0;
         burst_fin_in   = s1_entry_ff.fin;
         burst_bare_in  = (n_words == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_valid_ff    <= 1'b0;
         burst_idx_ff      <= '0;
         burst_count_ff    <= 3'd1;
         burst_fin_ff      <= 1'b0;
         burst_bare_ff     <= 1'b0;
         held_plain_ff     <= '0;
         held_valid_ff     <= 1'b0;
         previous_plain_ff <= '0;
         previous_valid_ff <= 1'b0;
      end else begin
         burst_valid_ff <= burst_valid_in;
         burst_idx_ff   <= burst_idx_in;
         burst_count_ff <= burst_count_in;
         burst_fin_ff   <= burst_fin_in;
         burst_bare_ff  <= burst_bare_in;
         if (s1_move) begin
            held_plain_ff     <= held_plain_in;
            held_valid_ff     <= held_valid_in;
            previous_plain_ff <= previous_plain_in;
            previous_valid_ff <= previous_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      burst_words_ff <= burst_words_in;
   end

   assign rsp_valid          = burst_valid_ff;
   assign rsp_letter_valid   = !burst_bare_ff;
   assign rsp_letter_out     = burst_bare_ff ? 7'd0
                             : 7'(ASCII_UPPER_A + {3'b000, burst_words_ff[burst_idx_ff]});
   assign rsp_end_of_message = burst_fin_ff && last_word;

endmodule

### sv/playfair_stream_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_stream_cipher
// Playfair cipher over a byte stream, with a configured 5x5 key square.
// ----------------------------------------------------------------------------
// Text bytes enter on the req channel, one word per byte, the last byte of a
// message carrying req_final_byte. Non-letters are dropped, letters are
// upper-cased and J is read as I. In encrypt mode letters are paired, an X is
// put between a doubled pair and after a lone trailing letter, and each pair
// is enciphered by the Playfair rules; in decrypt mode pairs are deciphered,
// an X between two equal letters and a final X are removed, and an unpaired
// trailing letter is dropped. Each rsp word carries one letter; a final byte
// that releases no letter gives one word with rsp_letter_valid low. The last
// word of a message has rsp_end_of_message high. The block takes one byte per
// cycle while the queue is not full; a byte releases zero to four letters on
// the result channel, and the queue lets new bytes enter while earlier letters
// are still being sent. The first letter of a pair passes the queue, the
// locate stage, which finds the pair in the square, and the transform into
// the output burst register before it leaves. The user must write the key
// square and mode through the csr port only while no message is in flight;
// the block does not enforce this. A cell value above 25 is read as Z, and a
// letter absent from the square is taken at the top left cell.
// ----------------------------------------------------------------------------
module playfair_stream_cipher #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [59:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_letter_out,
   output logic        rsp_letter_valid,
   output logic        rsp_end_of_message
);
   import pfc_pkg::*;

   logic             cipher_mode_ff;
   logic [59:0]      square_low_ff;
   logic [59:0]      square_mid_ff;
   letter_type       square_end_ff;
   square_type       square;

   logic             push_valid;
   digraph_type      push_entry;
   logic             pop, pop_valid;
   digraph_type      pop_entry;
   queue_status_type queue_status;

   // Config registers; user writes must land between messages, not enforced.
   always_ff @(posedge clock) begin
      if (reset) begin
         cipher_mode_ff <= 1'b0;
         square_low_ff  <= '0;
         square_mid_ff  <= '0;
         square_end_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_CIPHER_MODE: cipher_mode_ff <= csr_write_data[0];
            CSR_SQUARE_LOW:  square_low_ff  <= csr_write_data;
            CSR_SQUARE_MID:  square_mid_ff  <= csr_write_data;
            CSR_SQUARE_END:  square_end_ff  <= csr_write_data[4:0];
            default: ;
         endcase
      end
   end

   // Unpack the square; any cell code past Z reads as Z.
   always_comb begin
      for (int k = 0; k < 12; k++) begin
         square[k]      = (square_low_ff[5*k +: 5] > LETTER_Z) ? LETTER_Z
                        : square_low_ff[5*k +: 5];
         square[k + 12] = (square_mid_ff[5*k +: 5] > LETTER_Z) ? LETTER_Z
                        : square_mid_ff[5*k +: 5];
      end
      square[24] = (square_end_ff > LETTER_Z) ? LETTER_Z : square_end_ff;
   end

   pfc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cipher_mode    (cipher_mode_ff),
      .req_valid      (req_valid),
      .req_char_in    (req_char_in),
      .req_final_byte (req_final_byte),
      .req_stall      (req_stall),
      .queue_status   (queue_status),
      .push_valid     (push_valid),
      .push_entry     (push_entry)
   );

   pfc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .status     (queue_status)
   );

   pfc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .square             (square),
      .pop_valid          (pop_valid),
      .pop_entry          (pop_entry),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_letter_out     (rsp_letter_out),
      .rsp_letter_valid   (rsp_letter_valid),
      .rsp_end_of_message (rsp_end_of_message)
   );

   // A word that carries a letter always carries an upper-case one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_letter_valid |-> rsp_letter_out >= 7'd65 && rsp_letter_out <= 7'd90)
      else $error("letter word outside A to Z");

   // A word without a letter is only ever the bare end mark.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_letter_valid |-> rsp_end_of_message && rsp_letter_out == 7'd0)
      else $error("empty word that is not an end mark");

   // Reset leaves nothing to send and room in the queue.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !queue_status.full && !req_stall)
      else $error("state left over after reset");

endmodule

### test/playfair_stream_cipher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_stream_cipher_test
// Self-checking bench for the Playfair stream cipher.
// ----------------------------------------------------------------------------
// Text bytes are pushed into the req channel and every letter word that comes
// back on the rsp channel is compared with a letter computed by a Playfair
// model kept inside this bench, which tracks the key square, the mode and the
// open digraph just as the block should. A short directed part covers the
// pairing, filler and padding rules, bare end marks, odd key squares and a
// mode change inside a message. Random messages then run in four phases of
// sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module playfair_stream_cipher_test;
   import pfc_pkg::*;

   // One expected rsp word.
   typedef struct packed {
      logic [6:0] ascii;
      logic       has_letter;
      logic       last;
   } letter_word_type;

   // Cycles with no traffic at all before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 2000;
   // Cycles allowed for a byte that makes no letter to leave the pipeline.
   localparam int SETTLE_CYCLES  = 8;
   localparam int STEP_ENCRYPT   = 1;
   localparam int STEP_DECRYPT   = 4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_CIPHER_MODE;
   logic [59:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_in = '0;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [6:0]  rsp_letter_out;
   logic        rsp_letter_valid;
   logic        rsp_end_of_message;

   playfair_stream_cipher uut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_in        (req_char_in),
      .req_final_byte     (req_final_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_letter_out     (rsp_letter_out),
      .rsp_letter_valid   (rsp_letter_valid),
      .rsp_end_of_message (rsp_end_of_message)
   );

   // Copy of the configuration as this bench last wrote it.
   logic        mode_decrypt = 1'b0;
   logic [59:0] key_lo = '0;
   logic [59:0] key_mid = '0;
   letter_type  key_last = '0;

   // Cipher state: the open digraph, and on the decrypt side the letter that is
   // held back until we know whether it is a filler X, plus the one before it.
   letter_type  first_letter = '0;
   logic        first_ok = 1'b0;
   letter_type  hold_letter = '0;
   logic        hold_ok = 1'b0;
   letter_type  prior_letter = '0;
   logic        prior_ok = 1'b0;

   letter_word_type expected_words[$];
   letter_word_type burst[$];

   // Stimulus scratch: plaintext letters, their enciphered form, and the bytes
   // of the message about to be sent.
   letter_type  plain_q[$];
   letter_type  cipher_q[$];
   logic [7:0]  text_bytes[$];

   int idle_pct = 0;
   int stall_pct = 0;
   int failures = 0;
   int bytes_sent = 0;
   int words_checked = 0;
   int messages_closed = 0;
   int quiet_cycles = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Playfair model
   // ------------------------------------------------------------------------

   // Cells above Z read as Z.
   function automatic letter_type square_cell(input int k);
      letter_type v;
      if (k < 12)
         v = key_lo[5*k +: 5];
      else if (k < 24)
         v = key_mid[5*(k-12) +: 5];
      else
         v = key_last;
      return (v > LETTER_Z) ? LETTER_Z : v;
   endfunction

   // First matching cell in row-major order; a missing letter sits at the top
   // left corner.
   function automatic int square_find(input letter_type l);
      for (int k = 0; k < 25; k++) begin
         if (square_cell(k) == l)
            return k;
      end
      return 0;
   endfunction

   // The Playfair rule for one digraph. A step of one moves right or down, a
   // step of four is the same as moving left or up.
   task automatic playfair_map(input letter_type a, input letter_type b, input int step,
                               output letter_type x, output letter_type y);
      int p, q, r1, c1, r2, c2;
      p = square_find(a);
      q = square_find(b);
      r1 = p / 5;
      c1 = p % 5;
      r2 = q / 5;
      c2 = q % 5;
      if (r1 == r2) begin
         x = square_cell(r1 * 5 + (c1 + step) % 5);
         y = square_cell(r2 * 5 + (c2 + step) % 5);
      end else if (c1 == c2) begin
         x = square_cell(((r1 + step) % 5) * 5 + c1);
         y = square_cell(((r2 + step) % 5) * 5 + c2);
      end else begin
         x = square_cell(r1 * 5 + c2);
         y = square_cell(r2 * 5 + c1);
      end
   endtask

   task automatic push_letter(input letter_type l);
      letter_word_type w;
      w.ascii = 7'(ASCII_UPPER_A) + 7'(l);
      w.has_letter = 1'b1;
      w.last = 1'b0;
      if (burst.size() < 4)
         burst.push_back(w);
   endtask

   task automatic seal_pair(input letter_type a, input letter_type b);
      letter_type x, y;
      playfair_map(a, b, STEP_ENCRYPT, x, y);
      push_letter(x);
      push_letter(y);
   endtask

   // A decrypted letter enters the hold slot; the letter it pushes out is
   // released unless it is an X standing between two equal letters.
   task automatic release_plain(input letter_type p);
      if (hold_ok) begin
         if (!(hold_letter == LETTER_X && prior_ok && prior_letter == p))
            push_letter(hold_letter);
         prior_letter = hold_letter;
         prior_ok = 1'b1;
      end
      hold_letter = p;
      hold_ok = 1'b1;
   endtask

   // Works out the words that one accepted byte releases and queues them.
   task automatic predict_byte(input logic [7:0] ch, input logic fin);
      letter_type l, x, y;
      logic is_alpha;
      letter_word_type w;
      burst.delete();
      is_alpha = 1'b0;
      l = '0;
      if (ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_Z) begin
         l = letter_type'(ch - ASCII_UPPER_A);
         is_alpha = 1'b1;
      end else if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z) begin
         l = letter_type'(ch - ASCII_LOWER_A);
         is_alpha = 1'b1;
      end
      if (l == LETTER_J)
         l = LETTER_I;

      if (is_alpha) begin
         if (!first_ok) begin
            first_letter = l;
            first_ok = 1'b1;
         end else if (!mode_decrypt) begin
            // A doubled letter is split by an X and stays open.
            if (first_letter == l) begin
               seal_pair(first_letter, LETTER_X);
            end else begin
               seal_pair(first_letter, l);
               first_ok = 1'b0;
            end
         end else begin
            playfair_map(first_letter, l, STEP_DECRYPT, x, y);
            first_ok = 1'b0;
            release_plain(x);
            release_plain(y);
         end
      end

      if (fin) begin
         if (!mode_decrypt) begin
            if (first_ok)
               seal_pair(first_letter, LETTER_X);
         end else if (hold_ok && hold_letter != LETTER_X) begin
            push_letter(hold_letter);
         end
         first_letter = '0;
         hold_letter = '0;
         prior_letter = '0;
         first_ok = 1'b0;
         hold_ok = 1'b0;
         prior_ok = 1'b0;
         if (burst.size() == 0) begin
            w = '{ascii: 7'd0, has_letter: 1'b0, last: 1'b1};
            burst.push_back(w);
         end else begin
            w = burst[burst.size()-1];
            w.last = 1'b1;
            burst[burst.size()-1] = w;
         end
      end
      foreach (burst[i])
         expected_words.push_back(burst[i]);
   endtask

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // Called at a falling edge; returns at a falling edge with the word taken.
   // Valid is left high so that a following word can go out back to back.
   task automatic send_byte(input logic [7:0] ch, input logic fin);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_char_in <= ch;
      req_final_byte <= fin;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      predict_byte(ch, fin);
      bytes_sent++;
      if (fin)
         messages_closed++;
      @(negedge clock);
   endtask

   // Sends text_bytes as one message, the final mark on its last byte.
   task automatic send_text();
      foreach (text_bytes[i])
         send_byte(text_bytes[i], i == text_bytes.size() - 1);
   endtask

   // Lowers valid, waits for every expected word and lets the pipeline empty
   // of bytes that make no letter. Safe to write registers afterwards.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [59:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_CIPHER_MODE: mode_decrypt = data[0];
         CSR_SQUARE_LOW:  key_lo = data;
         CSR_SQUARE_MID:  key_mid = data;
         CSR_SQUARE_END:  key_last = data[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_square(input logic [59:0] lo, input logic [59:0] mid,
                               input logic [59:0] tail);
      write_csr(CSR_SQUARE_LOW, lo);
      write_csr(CSR_SQUARE_MID, mid);
      write_csr(CSR_SQUARE_END, tail);
   endtask

   // A proper key square: the 25 letters without J, in alphabet order or
   // shuffled.
   task automatic load_letter_square(input logic shuffle);
      letter_type cells[25];
      letter_type t;
      logic [59:0] lo, mid;
      int k, j;
      k = 0;
      for (int l = 0; l < 26; l++) begin
         if (letter_type'(l) != LETTER_J) begin
            cells[k] = letter_type'(l);
            k++;
         end
      end
      if (shuffle) begin
         for (int i = 24; i > 0; i--) begin
            j = $urandom_range(i);
            t = cells[i];
            cells[i] = cells[j];
            cells[j] = t;
         end
      end
      for (int i = 0; i < 12; i++) begin
         lo[5*i +: 5] = cells[i];
         mid[5*i +: 5] = cells[i+12];
      end
      write_square(lo, mid, 60'(cells[24]));
   endtask

   // Any byte case, and J now and then where the letter is I.
   function automatic logic [7:0] letter_char(input letter_type l);
      if (l == LETTER_I && $urandom_range(3) == 0)
         l = LETTER_J;
      if ($urandom_range(1))
         return ASCII_LOWER_A + 8'(l);
      return ASCII_UPPER_A + 8'(l);
   endfunction

   // Plaintext rich in doubled letters and X, so that fillers and their
   // removal happen often.
   task automatic fill_plain(input int n);
      int r;
      plain_q.delete();
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 20 && i > 0)
            plain_q.push_back(plain_q[i-1]);
         else if (r < 32)
            plain_q.push_back(LETTER_X);
         else
            plain_q.push_back(letter_type'($urandom_range(25)));
      end
   endtask

   // Enciphers plain_q into cipher_q under the current square, so that the
   // decrypt side can be fed text that deciphers into real plaintext.
   task automatic encipher_plain();
      letter_type a, b, x, y;
      int i;
      cipher_q.delete();
      i = 0;
      while (i < plain_q.size()) begin
         a = (plain_q[i] == LETTER_J) ? LETTER_I : plain_q[i];
         b = LETTER_X;
         if (i + 1 < plain_q.size()) begin
            b = (plain_q[i+1] == LETTER_J) ? LETTER_I : plain_q[i+1];
            if (a == b)
               b = LETTER_X;
            else
               i++;
         end
         i++;
         playfair_map(a, b, STEP_ENCRYPT, x, y);
         cipher_q.push_back(x);
         cipher_q.push_back(y);
      end
   endtask

   // ------------------------------------------------------------------------
   // Receiver, checker and watchdog
   // ------------------------------------------------------------------------

   always @(negedge clock)
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin : check_words
      letter_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("rsp word with nothing expected: letter_out %0d letter_valid %0b",
                   rsp_letter_out, rsp_letter_valid);
            failures++;
         end else begin
            want = expected_words.pop_front();
            words_checked++;
            if (rsp_letter_out !== want.ascii) begin
               $error("letter_out: expected %0d, got %0d", want.ascii, rsp_letter_out);
               failures++;
            end
            if (rsp_letter_valid !== want.has_letter) begin
               $error("letter_valid: expected %0b, got %0b", want.has_letter,
                      rsp_letter_valid);
               failures++;
            end
            if (rsp_end_of_message !== want.last) begin
               $error("end_of_message: expected %0b, got %0b", want.last,
                      rsp_end_of_message);
               failures++;
            end
         end
      end
   end

   // Any accepted word or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          csr_write_enable) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no traffic for %0d cycles, %0d words still expected",
                     quiet_cycles, expected_words.size());
            $display("playfair_stream_cipher verification failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Out of reset every cell is A, so any other letter is missing and falls
   // on the top left cell. A doubled letter followed by the final mark gives
   // the longest burst, four words.
   task automatic test_reset_defaults();
      text_bytes = '{"q", "Q"};
      send_text();
      wait_drained();
   endtask

   // Alphabet square: same row, same column, rectangle, wrap to the top
   // edge, doubled X, J read as I, lower case, non-letters in between, and a
   // lone letter padded with X at the final mark.
   task automatic test_encrypt_rules();
      write_csr(CSR_CIPHER_MODE, 60'd0);
      load_letter_square(1'b0);
      text_bytes = '{"A", "b", "a", "F", "@", "a", "g", "E", "Z", "X", "x",
                     "J", "j", "{"};
      send_text();
      wait_drained();
   endtask

   // A final mark on a non-letter with nothing open gives a bare end word.
   // The bytes on either side of the letter ranges must all be ignored.
   task automatic test_end_marks();
      text_bytes = '{"[", 8'h60, 8'h00};
      send_text();
      text_bytes = '{8'hFF};
      send_text();
      wait_drained();
   endtask

   // Plaintext L L C A enciphers as LX LC AX: the X between the two L is
   // removed and the final X is dropped. Then an odd cipher text, whose last
   // letter has no partner and is dropped.
   task automatic test_decrypt_rules();
      write_csr(CSR_CIPHER_MODE, 60'd1);
      plain_q = '{5'd11, 5'd11, 5'd2, 5'd0};
      encipher_plain();
      text_bytes.delete();
      foreach (cipher_q[i])
         text_bytes.push_back(letter_char(cipher_q[i]));
      send_text();
      text_bytes = '{"A", "b", "C"};
      send_text();
      wait_drained();
   endtask

   // The mode changes while a message is open; the state carries over and the
   // held letter is not flushed when the message closes in encrypt mode.
   task automatic test_mode_switch();
      write_csr(CSR_CIPHER_MODE, 60'd0);
      send_byte("K", 1'b0);
      wait_drained();
      write_csr(CSR_CIPHER_MODE, 60'd1);
      send_byte("M", 1'b0);
      wait_drained();
      write_csr(CSR_CIPHER_MODE, 60'd0);
      send_byte("P", 1'b1);
      wait_drained();
   endtask

   // Cells above Z, repeated letters and all-ones register data, which the
   // block must cut to each register's width.
   task automatic test_odd_squares();
      write_square('1, '0, '1);
      text_bytes = '{"z", "A"};
      send_text();
      wait_drained();
      write_csr(CSR_CIPHER_MODE, '1);
      text_bytes = '{"Q", "z", "r"};
      send_text();
      wait_drained();
   endtask

   // One random message under a fresh mode and now and then a fresh square.
   // Most are well formed, the rest broken pairs or plain byte noise.
   task automatic random_message();
      int kind, r;
      wait_drained();
      write_csr(CSR_CIPHER_MODE, 60'($urandom_range(1)));
      if ($urandom_range(99) < 40) begin
         r = $urandom_range(99);
         if (r < 70)
            load_letter_square(1'b1);
         else if (r < 88)
            write_square(60'({$urandom, $urandom}), 60'({$urandom, $urandom}),
                         60'($urandom));
         else if (r < 94)
            write_square('1, '1, '1);
         else
            write_square('0, '0, '0);
      end
      text_bytes.delete();
      kind = $urandom_range(99);
      if (kind < 65) begin
         fill_plain($urandom_range(1, 14));
         if (mode_decrypt)
            encipher_plain();
         else
            cipher_q = plain_q;
         foreach (cipher_q[i]) begin
            if ($urandom_range(99) < 10)
               text_bytes.push_back(8'($urandom_range(255)));
            text_bytes.push_back(letter_char(cipher_q[i]));
         end
      end else if (kind < 85) begin
         repeat ($urandom_range(1, 9)) begin
            if ($urandom_range(99) < 30)
               text_bytes.push_back(8'($urandom_range(255)));
            text_bytes.push_back(letter_char(letter_type'($urandom_range(25))));
         end
      end else begin
         repeat ($urandom_range(1, 5))
            text_bytes.push_back(8'($urandom_range(255)));
      end
      send_text();
   endtask

   task automatic test_random_phase(input int idle, input int stall, input int budget);
      int start;
      idle_pct = idle;
      stall_pct = stall;
      start = bytes_sent;
      while (bytes_sent - start < budget)
         random_message();
      wait_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_encrypt_rules();
      test_end_marks();
      test_decrypt_rules();
      test_mode_switch();
      test_odd_squares();

      // No idling, a slow sender, a slow receiver, then light gaps on both.
      test_random_phase(0, 0, 80);
      test_random_phase(70, 0, 80);
      test_random_phase(0, 70, 80);
      test_random_phase(14, 14, 80);

      $display("covered: %0d text bytes in %0d messages, %0d letter words checked",
               bytes_sent, messages_closed, words_checked);
      $display("both modes, proper and malformed key squares, four handshake phases");
      if (failures == 0) begin
         $display("playfair_stream_cipher verification clean");
      end else begin
         $display("%0d mismatches", failures);
         $display("playfair_stream_cipher verification failed");
      end
      $finish;
   end

endmodule
